[hw/rtl/hfba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame block averager package
// Shared widths, defaults, state encoding and the structs that pass between
// the front end, the sample queue and the accumulator/divider back end.
// ----------------------------------------------------------------------------
package hfba_pkg;

   // Field and datapath widths.
   localparam int CHAR_W    = 8;
   localparam int SAMPLE_W  = 24;
   localparam int SUM_W     = 32;
   localparam int COUNT_W   = 8;
   localparam int BLOCK_W   = COUNT_W + 1;
   localparam int DIV_STEP_W = $clog2(SUM_W);

   // Reset value of the block size register and the default digit limit.
   localparam logic [COUNT_W-1:0] DEFAULT_SAMPLES    = 8'd16;
   localparam int                 DEFAULT_MAX_DIGITS = 6;

   // Sample queue geometry.
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   // Back end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_DONE
   } back_state_type;

   // One finished sample travelling through the queue.
   typedef struct packed {
      logic                valid;
      logic [SAMPLE_W-1:0] sample;
   } sample_type;

   // Queue fill information.
   typedef struct packed {
      logic                     full;
      logic [QUEUE_LEVEL_W-1:0] level;
   } queue_status_type;

   // Back end activity flags.
   typedef struct packed {
      logic dividing;
      logic out_load;
   } back_status_type;

endpackage

[hw/rtl/hfba_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame block averager front end
// Parses the message one character per transfer, builds the hex sample and
// pushes it into the sample queue on the last character.
// ----------------------------------------------------------------------------
module hfba_front #(
   parameter int MaxDigits = hfba_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [hfba_pkg::CHAR_W-1:0] req_char_code,
   input  logic                        req_end_of_message,
   input  logic                        queue_full,
   output hfba_pkg::sample_type        push
);
   import hfba_pkg::*;

   localparam int DIGIT_W = $clog2(MaxDigits + 1);

   logic                odd_ff, odd_in;
   logic [DIGIT_W-1:0]  digits_ff, digits_in;
   logic [SAMPLE_W-1:0] value_ff, value_in;
   logic                bad_ff, bad_in;
   logic                accept;
   logic [4:0]          nibble;

   // Hex decode: bit 4 set means the character is not a hex digit.
   function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b0, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b0, 4'(c - 8'h57)};
      end
      return r;
   endfunction

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign nibble    = hex_nibble(req_char_code);

   // Message state update; the sample is taken before the message clears.
   always_comb begin
      odd_in      = odd_ff;
      digits_in   = digits_ff;
      value_in    = value_ff;
      bad_in      = bad_ff;
      push.valid  = 1'b0;
      push.sample = '0;
      if (accept) begin
         if (odd_ff) begin
            if (nibble[4]) begin
               bad_in = 1'b1;
            end else if (digits_ff >= DIGIT_W'(MaxDigits)) begin
               bad_in = 1'b1;
            end else if (value_ff[SAMPLE_W-1 -: 4] != 4'h0) begin
               bad_in = 1'b1;
            end else begin
               value_in  = {value_ff[SAMPLE_W-5:0], nibble[3:0]};
               digits_in = digits_ff + 1'b1;
            end
         end
         odd_in = !odd_ff;
         if (req_end_of_message) begin
            push.valid  = 1'b1;
            push.sample = bad_in ? '0 : value_in;
            odd_in      = 1'b0;
            digits_in   = '0;
            value_in    = '0;
            bad_in      = 1'b0;
         end
      end
   end

   // Message state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff    <= 1'b0;
         digits_ff <= '0;
         value_ff  <= '0;
         bad_ff    <= 1'b0;
      end else begin
         odd_ff    <= odd_in;
         digits_ff <= digits_in;
         value_ff  <= value_in;
         bad_ff    <= bad_in;
      end
   end

endmodule

[hw/rtl/hfba_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame block averager sample queue
// A short first-in first-out buffer of finished samples that decouples the
// character front end from the accumulator and divider.
// ----------------------------------------------------------------------------
module hfba_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  hfba_pkg::sample_type       push,
   input  logic                       pop_ready,
   output hfba_pkg::sample_type       pop_item,
   output hfba_pkg::queue_status_type status
);
   import hfba_pkg::*;

   logic [SAMPLE_W-1:0]      entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_LEVEL_W-1:0] level_ff;
   logic                     do_pop;

   assign pop_item.valid  = (level_ff != '0);
   assign pop_item.sample = entry_ff[rd_ptr_ff];
   assign do_pop          = pop_ready && pop_item.valid;
   assign status.full     = (level_ff == QUEUE_LEVEL_W'(QUEUE_DEPTH));
   assign status.level    = level_ff;

   // Storage; the front end never pushes into a full queue.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.sample;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push.valid && !do_pop) begin
            level_ff <= level_ff + 1'b1;
         end else if (!push.valid && do_pop) begin
            level_ff <= level_ff - 1'b1;
         end
      end
   end

endmodule

[hw/rtl/hfba_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame block averager back end
// Accumulates queued samples and, when a block is complete, divides the sum
// by the sample count one quotient bit per cycle before offering the mean.
// ----------------------------------------------------------------------------
module hfba_back (
   input  logic                          clock,
   input  logic                          reset,
   input  hfba_pkg::sample_type          pop_item,
   output logic                          pop_ready,
   input  logic [hfba_pkg::COUNT_W-1:0]  samples_per_average,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hfba_pkg::SAMPLE_W-1:0] rsp_average,
   output hfba_pkg::back_status_type     status
);
   import hfba_pkg::*;

   back_state_type          state_ff, state_in;
   logic [SUM_W-1:0]        sum_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [BLOCK_W-1:0]      divisor_ff;
   logic [BLOCK_W-1:0]      rem_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic [DIV_STEP_W-1:0]   step_ff;
   logic                    rsp_valid_ff;
   logic [SAMPLE_W-1:0]     average_ff;

   logic                    take;
   logic                    div_step;
   logic                    out_load;
   logic                    out_free;
   logic                    last_step;
   logic [SUM_W-1:0]        sum_next;
   logic [BLOCK_W-1:0]      count_next;
   logic [BLOCK_W-1:0]      block_size;
   logic                    emit;
   logic [BLOCK_W:0]        trial;
   logic                    trial_ok;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == DIV_STEP_W'(SUM_W - 1));

   // Block bookkeeping for the sample at the queue head.
   assign sum_next   = sum_ff + SUM_W'(pop_item.sample);
   assign count_next = {1'b0, count_ff} + 1'b1;
   assign block_size = (samples_per_average == '0) ? BLOCK_W'(1 << COUNT_W)
                                                   : {1'b0, samples_per_average};
   assign emit       = (count_next >= block_size);

   // One restoring division step.
   assign trial    = {rem_ff, quo_ff[SUM_W-1]};
   assign trial_ok = (trial >= {1'b0, divisor_ff});

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (pop_item.valid && emit) begin
               state_in = BK_DIV;
            end
         end
         BK_DIV: begin
            if (last_step) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      pop_ready = 1'b0;
      div_step  = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop_ready = 1'b1;
         BK_DIV:  div_step  = 1'b1;
         BK_DONE: out_load  = out_free;
         default: pop_ready = 1'b0;
      endcase
   end

   assign take = pop_ready && pop_item.valid;

   // Sequencer and output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (take) begin
            if (emit) begin
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_next;
               count_ff <= count_next[COUNT_W-1:0];
            end
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Divider datapath and output register.
   always_ff @(posedge clock) begin
      if (take && emit) begin
         quo_ff     <= sum_next;
         divisor_ff <= count_next;
         rem_ff     <= '0;
         step_ff    <= '0;
      end else if (div_step) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], trial_ok};
         rem_ff  <= trial_ok ? BLOCK_W'(trial - {1'b0, divisor_ff}) : trial[BLOCK_W-1:0];
         step_ff <= step_ff + 1'b1;
      end
      if (out_load) begin
         average_ff <= quo_ff[SAMPLE_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average     = average_ff;
   assign status.dividing = (state_ff == BK_DIV) || (state_ff == BK_DONE);
   assign status.out_load = out_load;

endmodule

[hw/rtl/hex_frame_block_averager.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex frame block averager
// Decodes hex samples from converter messages and emits the truncated mean
// of every block of samples_per_average samples.
// ----------------------------------------------------------------------------
// The front end takes one character per cycle while the queue is not
// full and pushes each finished sample into a two-entry queue; the back
// end adds each queued sample to the block sum. At the end of a block the
// sum is divided by the sample count in a bit-serial restoring divider
// and the mean is then loaded into the output register. Characters keep
// flowing meanwhile, and the input stalls, whatever character is offered,
// only while the queue is full. A value of 0 in the block size register
// means 256 samples. MaxDigits (1 to 15) limits the number of hex digits
// in a message.
module hex_frame_block_averager #(
   parameter int MaxDigits = hfba_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hfba_pkg::CHAR_W-1:0]   req_char_code,
   input  logic                          req_end_of_message,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hfba_pkg::SAMPLE_W-1:0] rsp_average,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [hfba_pkg::COUNT_W-1:0]  csr_samples_per_average
);
   import hfba_pkg::*;

   logic [COUNT_W-1:0] spa_ff;
   sample_type         push;
   sample_type         pop_item;
   logic               pop_ready;
   queue_status_type   q_status;
   back_status_type    b_status;

   // Block size register; a write transfer is always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spa_ff <= DEFAULT_SAMPLES;
      end else if (csr_valid && csr_ready) begin
         spa_ff <= csr_samples_per_average;
      end
   end

   hfba_front #(
      .MaxDigits (MaxDigits)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_char_code      (req_char_code),
      .req_end_of_message (req_end_of_message),
      .queue_full         (q_status.full),
      .push               (push)
   );

   hfba_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   hfba_back u_back (
      .clock               (clock),
      .reset               (reset),
      .pop_item            (pop_item),
      .pop_ready           (pop_ready),
      .samples_per_average (spa_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_average         (rsp_average),
      .status              (b_status)
   );

   // The queue never holds more than its depth.
   a_queue_level : assert property (@(posedge clock) disable iff (reset)
      q_status.level <= QUEUE_LEVEL_W'(QUEUE_DEPTH))
      else $error("sample queue overfilled");

   // No sample leaves the queue while a division is in flight.
   a_no_pop_dividing : assert property (@(posedge clock) disable iff (reset)
      b_status.dividing |-> !pop_ready)
      else $error("queue popped during division");

   // A waiting mean is never overwritten.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !b_status.out_load)
      else $error("pending mean overwritten");

   // A mean appears only after the divider has handed one over.
   a_mean_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(b_status.out_load))
      else $error("mean offered without a division");

endmodule
